FILE: hw/rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the sobel edge threshold block.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned THR_W  = 8;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned GRAD_W = 11;
  localparam int unsigned SQ_W   = 20;
  localparam int unsigned MAG_W  = SQ_W + 1;
  localparam int unsigned ADDR_W = 4;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(480);
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(50);
  localparam logic [SIZE_W-1:0] MIN_SIZE        = SIZE_W'(3);
  localparam logic [PIX_W-1:0]  PIX_WHITE       = '1;
  localparam logic [PIX_W-1:0]  PIX_BLACK       = '0;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             last_of_run;
  } pix_out_t;

  // per-pixel sideband carried down the pipeline
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_in_t          pix;
    logic             has_int;
    logic             has_bord;
  } meta_t;

  // clamp a size register to [3, maxv], return size minus one
  function automatic logic [COL_W-1:0] size_minus_one(logic [SIZE_W-1:0] v,
                                                      logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] s;
    s = v;
    if (v < MIN_SIZE) s = MIN_SIZE;
    else if (v > maxv) s = maxv;
    return COL_W'(s - SIZE_W'(1));
  endfunction

endpackage

FILE: hw/rtl/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 sobel edge detector on the blue channel with threshold.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_* valid/ready channel, one word per
// pixel. Results leave on the out_* channel, each word carrying its row and
// column. A border pixel is passed through unchanged; an interior centre is
// emitted white or black once the pixel below and right of it arrives. When
// one pixel yields two words, the interior centre comes first and the border
// passthrough second; last_of_run marks the final word of a pixel.
// One pixel is taken per cycle while the first stage is free; pixels that
// cause two words hold the output stage until both are taken, so throughput
// is one output word per cycle while the receiver is ready. The two previous
// rows of blue live in one 2048 x 16 line RAM with one read (at accept) and
// one write (when the pixel leaves the first stage) per pixel.
// The pipeline is elastic: while the receiver stalls, stages keep filling
// and input is taken until the pipeline is full. Reset clears the counters,
// the 3x3 window and the pipeline and loads the default sizes (640 x 480,
// threshold 50). The line RAM is not cleared. The user must write
// configuration over the APB port while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module sobel_edge_threshold
  import sobel_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic [SIZE_W-1:0] width_q, height_q;
  logic [THR_W-1:0]  thr_q;
  logic [2*THR_W-1:0] thr_sq_q;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      thr_q    <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH:    width_q  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_q <= pwdata[SIZE_W-1:0];
        REG_EDGE_THRESHOLD: thr_q    <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:    prdata = 32'(width_q);
      REG_FRAME_HEIGHT:   prdata = 32'(height_q);
      REG_EDGE_THRESHOLD: prdata = 32'(thr_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= (2*THR_W)'(thr_q) * (2*THR_W)'(thr_q);
  end

  assign wm1 = size_minus_one(width_q, SIZE_W'(MAX_WIDTH));
  assign hm1 = ROW_W'(size_minus_one(height_q, SIZE_W'(MAX_HEIGHT)));

  // pipeline handshake
  logic [5:1] v_q;
  logic [5:1] mv;
  logic [5:1] rdy;
  meta_t      meta_q [1:5];
  logic       in_acc;

  assign rdy[1] = !v_q[1] || mv[1];
  assign rdy[2] = !v_q[2] || mv[2];
  assign rdy[3] = !v_q[3] || mv[3];
  assign rdy[4] = !v_q[4] || mv[4];
  assign mv[1]  = v_q[1] && rdy[2];
  assign mv[2]  = v_q[2] && rdy[3];
  assign mv[3]  = v_q[3] && rdy[4];
  assign mv[4]  = v_q[4] && rdy[5];

  assign in_ready_o = rdy[1];
  assign in_acc     = in_valid_i && in_ready_o;

  // position counters
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  meta_t            meta_in;

  always_comb begin
    meta_in.row      = row_q;
    meta_in.col      = col_q;
    meta_in.pix      = in_data_i;
    meta_in.has_int  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2)) &&
                       (row_q <= hm1) && (col_q <= wm1);
    meta_in.has_bord = (row_q == '0) || (row_q >= hm1) ||
                       (col_q == '0) || (col_q >= wm1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (col_q >= wm1) begin
        col_q <= '0;
        row_q <= (row_q >= hm1) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // line RAM: upper byte two rows up, lower byte previous row
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic               mem_we;

  assign mem_we = mv[1];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[meta_q[1].col] <= {rd_q[PIX_W-1:0], meta_q[1].pix.blue_in};
    end
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
  end

  // 3x3 window, newest column at index 2 of each row
  logic [PIX_W-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (mv[1]) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3+0] <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= rd_q[2*PIX_W-1:PIX_W];
      win_q[5] <= rd_q[PIX_W-1:0];
      win_q[8] <= meta_q[1].pix.blue_in;
    end
  end

  // gradients
  logic signed [GRAD_W-1:0] q [9];
  logic signed [GRAD_W-1:0] dx, dy, dx_q, dy_q;
  logic signed [2*GRAD_W-1:0] px, py;
  logic [SQ_W-1:0]  sqx_q, sqy_q;
  logic [MAG_W-1:0] mag2;
  logic [MAG_W-1:0] lim;
  logic             edge_q;

  always_comb begin
    for (int i = 0; i < 9; i++) q[i] = $signed({{(GRAD_W-PIX_W){1'b0}}, win_q[i]});
    dx = q[2] - q[0] + (q[5] <<< 1) - (q[3] <<< 1) + q[8] - q[6];
    dy = q[6] + (q[7] <<< 1) + q[8] - q[0] - (q[1] <<< 1) - q[2];
  end

  assign px   = (2*GRAD_W)'(dx_q) * (2*GRAD_W)'(dx_q);
  assign py   = (2*GRAD_W)'(dy_q) * (2*GRAD_W)'(dy_q);
  assign mag2 = MAG_W'(sqx_q) + MAG_W'(sqy_q);
  assign lim  = MAG_W'({thr_sq_q, 4'b0000});

  always_ff @(posedge clk_i) begin
    if (mv[2]) begin
      dx_q <= dx;
      dy_q <= dy;
    end
    if (mv[3]) begin
      sqx_q <= px[SQ_W-1:0];
      sqy_q <= py[SQ_W-1:0];
    end
    if (mv[4]) begin
      edge_q <= mag2 > lim;
    end
  end

  // stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= in_acc;
      if (rdy[2]) v_q[2] <= mv[1];
      if (rdy[3]) v_q[3] <= mv[2];
      if (rdy[4]) v_q[4] <= mv[3];
      if (rdy[5]) v_q[5] <= mv[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) meta_q[1] <= meta_in;
    if (mv[1])  meta_q[2] <= meta_q[1];
    if (mv[2])  meta_q[3] <= meta_q[2];
    if (mv[3])  meta_q[4] <= meta_q[3];
    if (mv[4])  meta_q[5] <= meta_q[4];
  end

  // output stage: interior word first, then border word
  logic       sent_q;
  logic       any_res;
  logic       cur_int;
  logic       cur_last;
  logic       out_acc;
  logic [PIX_W-1:0] bw;

  assign any_res  = meta_q[5].has_int || meta_q[5].has_bord;
  assign cur_int  = meta_q[5].has_int && !sent_q;
  assign cur_last = !(cur_int && meta_q[5].has_bord);
  assign out_valid_o = v_q[5] && any_res;
  assign out_acc  = out_valid_o && out_ready_i;
  assign mv[5]    = v_q[5] && (!any_res || (out_ready_i && cur_last));
  assign rdy[5]   = !v_q[5] || mv[5];
  assign bw       = edge_q ? PIX_WHITE : PIX_BLACK;

  always_comb begin
    if (cur_int) begin
      out_data_o.out_row   = meta_q[5].row - ROW_W'(1);
      out_data_o.out_col   = meta_q[5].col - COL_W'(1);
      out_data_o.red_out   = bw;
      out_data_o.green_out = bw;
      out_data_o.blue_out  = bw;
    end else begin
      out_data_o.out_row   = meta_q[5].row;
      out_data_o.out_col   = meta_q[5].col;
      out_data_o.red_out   = meta_q[5].pix.red_in;
      out_data_o.green_out = meta_q[5].pix.green_in;
      out_data_o.blue_out  = meta_q[5].pix.blue_in;
    end
    out_data_o.last_of_run = cur_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= 1'b0;
    end else if (out_acc) begin
      sent_q <= !cur_last;
    end
  end

  // the RAM write of one pixel never meets the read of the next at one address
  a_ram_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && in_acc) |-> (meta_q[1].col != col_q))
    else $error("line RAM read and write collide");

  // a second word is only pending for a pixel that has both
  a_sent_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> (v_q[5] && meta_q[5].has_int && meta_q[5].has_bord))
    else $error("second word pending without a two-word pixel");

  // after a non-final word the closing word of the same pixel follows
  a_second_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !cur_last) |=> (out_valid_o && cur_last && !cur_int))
    else $error("second word of a pixel missing");

endmodule

FILE: bench/sobel_edge_threshold_test.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold_test
// Self-checking bench for the streaming sobel edge threshold block: pixels
// are queued batch by batch, driven under several idling patterns, and every
// output word is compared against a cycle-free software copy of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_threshold_test;
  import sobel_pkg::*;

  typedef enum int {
    CONTENT_RANDOM,
    CONTENT_FLAT,
    CONTENT_RAMP,
    CONTENT_NOISE,
    CONTENT_BINARY,
    CONTENT_STEP_EDGE
  } content_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  pix_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pix_out_t          out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  sobel_edge_threshold dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // filter state mirrored in software
  logic [SIZE_W-1:0] cfg_width  = WIDTH_RESET;
  logic [SIZE_W-1:0] cfg_height = HEIGHT_RESET;
  logic [THR_W-1:0]  cfg_thresh = THRESHOLD_RESET;
  int                line_prev  [MAX_WIDTH] = '{default: 0};
  int                line_prev2 [MAX_WIDTH] = '{default: 0};
  int                win [9] = '{default: 0};
  int                pos_row = 0;
  int                pos_col = 0;

  pix_in_t           pixel_queue [$];
  pix_out_t          expected_words [$];
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              hold_words = 1'b0;
  logic              pressure_go = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp_dim(logic [SIZE_W-1:0] v, int maxv);
    if (v < MIN_SIZE) return int'(MIN_SIZE);
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // pixels still needed before the counters wrap back to the frame start
  function automatic int pixels_to_frame_end();
    int w, h, rest;
    if (pos_row == 0 && pos_col == 0) return 0;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    rest = (pos_col >= w - 1) ? 1 : w - pos_col;
    if (pos_row < h - 1) rest += (h - 1 - pos_row) * w;
    return rest;
  endfunction

  task automatic predict_pixel(input pix_in_t px);
    int w, h, r, c, idx, dx, dy, n, up1, up2;
    logic [PIX_W-1:0] v;
    pix_out_t words [2];
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    r = pos_row;
    c = pos_col;
    idx = (c < MAX_WIDTH) ? c : 0;
    up1 = line_prev[idx];
    up2 = line_prev2[idx];
    for (int k = 0; k < 3; k++) begin
      win[k * 3 + 0] = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = int'(px.blue_in);
    line_prev2[idx] = up1;
    line_prev[idx] = int'(px.blue_in);
    n = 0;
    if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
      dx = win[2] - win[0] + 2 * (win[5] - win[3]) + win[8] - win[6];
      dy = win[6] + 2 * win[7] + win[8] - win[0] - 2 * win[1] - win[2];
      v = (dx * dx + dy * dy > 16 * int'(cfg_thresh) * int'(cfg_thresh)) ?
          PIX_WHITE : PIX_BLACK;
      words[n] = '{out_row: ROW_W'(r - 1), out_col: COL_W'(c - 1), red_out: v,
                   green_out: v, blue_out: v, last_of_run: 1'b0};
      n++;
    end
    if (r == 0 || r >= h - 1 || c == 0 || c >= w - 1) begin
      words[n] = '{out_row: ROW_W'(r), out_col: COL_W'(c), red_out: px.red_in,
                   green_out: px.green_in, blue_out: px.blue_in, last_of_run: 1'b0};
      n++;
    end
    if (n > 0) words[n - 1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) expected_words.push_back(words[k]);
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  // pixel driver; prediction happens on the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_pixel(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= pixel_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    pix_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word at row %0d col %0d",
                 out_data_o.out_row, out_data_o.out_col);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_data_o.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_data_o.out_row);
            error_count++;
          end
          if (out_data_o.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, out_data_o.out_col);
            error_count++;
          end
          if (out_data_o.red_out !== want.red_out) begin
            $error("red_out: expected %0d, got %0d", want.red_out, out_data_o.red_out);
            error_count++;
          end
          if (out_data_o.green_out !== want.green_out) begin
            $error("green_out: expected %0d, got %0d", want.green_out,
                   out_data_o.green_out);
            error_count++;
          end
          if (out_data_o.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want.blue_out, out_data_o.blue_out);
            error_count++;
          end
          if (out_data_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   out_data_o.last_of_run);
            error_count++;
          end
        end
      end
      out_ready_i <= !hold_words && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_words <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_words <= 1'b0;
  end

  task automatic write_reg(input logic [1:0] index, input int field);
    logic [31:0] mask, bus_word;
    mask = (index == REG_EDGE_THRESHOLD) ? 32'(PIX_WHITE) : {{(32 - SIZE_W){1'b0}},
                                                             {SIZE_W{1'b1}}};
    // junk above the register width must be ignored
    bus_word = ($urandom() & ~mask) | (32'(field) & mask);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({index, 2'b00});
    pwdata <= bus_word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_FRAME_WIDTH:    cfg_width = bus_word[SIZE_W-1:0];
      REG_FRAME_HEIGHT:   cfg_height = bus_word[SIZE_W-1:0];
      REG_EDGE_THRESHOLD: cfg_thresh = bus_word[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_idling(input idle_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 76; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      IDLE_BOTH:     begin send_idle_pct = 23; recv_stall_pct = 23; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic queue_pixels(input int count, input content_e style);
    logic [PIX_W-1:0] base, step;
    pix_in_t px;
    base = PIX_W'($urandom());
    step = PIX_W'($urandom_range(1, 40));
    for (int k = 0; k < count; k++) begin
      px.red_in = PIX_W'($urandom());
      px.green_in = PIX_W'($urandom());
      case (style)
        CONTENT_FLAT:  px.blue_in = base;
        CONTENT_RAMP:  px.blue_in = base + PIX_W'(k) * step;
        CONTENT_NOISE: px.blue_in = base + PIX_W'($urandom_range(0, 12));
        CONTENT_BINARY: begin
          px.red_in = px.red_in[0] ? PIX_WHITE : PIX_BLACK;
          px.green_in = px.green_in[0] ? PIX_WHITE : PIX_BLACK;
          px.blue_in = ($urandom_range(1) != 0) ? PIX_WHITE : PIX_BLACK;
        end
        // vertical step: dark left column, bright right column
        CONTENT_STEP_EDGE: begin
          if (k % 3 == 0) px.blue_in = PIX_BLACK;
          else if (k % 3 == 1) px.blue_in = 8'h80;
          else px.blue_in = PIX_WHITE;
        end
        default: px.blue_in = PIX_W'($urandom());
      endcase
      pixel_queue.push_back(px);
    end
  endtask

  task automatic drain_pipeline();
    while (pixel_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    // pixels with no result may still be in flight
    repeat (8) @(posedge clk_i);
  endtask

  task automatic pick_config();
    int pick;
    if ($urandom_range(9) < 8) begin
      pick = $urandom_range(9);
      if (pick == 0) write_reg(REG_FRAME_WIDTH, $urandom_range(0, 2));
      else if (pick == 1) write_reg(REG_FRAME_WIDTH, $urandom_range(25, 64));
      else write_reg(REG_FRAME_WIDTH, $urandom_range(3, 24));
    end
    if ($urandom_range(9) < 8) begin
      if ($urandom_range(9) == 0) write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 2));
      else write_reg(REG_FRAME_HEIGHT, $urandom_range(3, 8));
    end
    if ($urandom_range(9) < 7) begin
      pick = $urandom_range(9);
      if (pick < 3) write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 20));
      else if (pick == 3) write_reg(REG_EDGE_THRESHOLD, 0);
      else if (pick == 4) write_reg(REG_EDGE_THRESHOLD, 255);
      else write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 255));
    end
  endtask

  initial begin : stimulus
    int count, w, h, random_items, phase;
    content_e style;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest frame, threshold exactly at the gradient of a full step
    set_idling(IDLE_NONE);
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_EDGE_THRESHOLD, 255);
    queue_pixels(9, CONTENT_STEP_EDGE);
    drain_pipeline();
    write_reg(REG_EDGE_THRESHOLD, 254);
    queue_pixels(9, CONTENT_STEP_EDGE);
    drain_pipeline();
    write_reg(REG_EDGE_THRESHOLD, 0);
    queue_pixels(9, CONTENT_FLAT);
    drain_pipeline();

    // widest frame clamped to the maximum: one full row and the start of the next
    write_reg(REG_FRAME_WIDTH, 4095);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_EDGE_THRESHOLD, 255);
    queue_pixels(MAX_WIDTH + 4, CONTENT_BINARY);
    drain_pipeline();
    // shrink mid-row so the current column turns into the row end
    write_reg(REG_FRAME_WIDTH, 3);

    random_items = 0;
    for (phase = 0; random_items < 400 || phase < 8; phase++) begin
      if (pos_row == 0 && pos_col == 0) begin
        pick_config();
      end else if ($urandom_range(1) != 0) begin
        // mid-frame change: width may only shrink so every column read was written
        write_reg(REG_FRAME_WIDTH, $urandom_range(3, clamp_dim(cfg_width, MAX_WIDTH)));
        if ($urandom_range(1) != 0) write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8));
      end
      set_idling(idle_e'(phase % 4));
      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      count = pixels_to_frame_end() + $urandom_range(1, 2) * w * h;
      if ($urandom_range(3) == 0) count += $urandom_range(1, w * h - 1);
      if (phase == 5) begin
        set_idling(IDLE_NONE);
        count += 2 * w * h;
        pressure_go = 1'b1;
      end
      style = content_e'($urandom_range(0, 4));
      queue_pixels(count, style);
      drain_pipeline();
      random_items += count;
    end

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sobel_edge_threshold.f
hw/rtl/sobel_pkg.sv
hw/rtl/sobel_edge_threshold.sv
bench/sobel_edge_threshold_test.sv
